[rtl/biq_pkg.sv]
package biq_pkg;

  localparam int SAMPLE_W = 14;
  localparam int COEF_W   = 16;
  localparam int OFFSET_W = 9;
  localparam int OPND_W   = 16;
  localparam int PROD_W   = COEF_W + OPND_W;
  // five products of at most 31 magnitude bits each, plus sign
  localparam int ACC_W    = 36;
  localparam int CNT_W    = $clog2(ACC_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int MAC_TAPS = 5;
  localparam int STEP_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0     = 3'd0,
    CFG_B1     = 3'd1,
    CFG_B2     = 3'd2,
    CFG_A1     = 3'd3,
    CFG_A2     = 3'd4,
    CFG_DIVISOR = 3'd5,
    CFG_OFFSET = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/biquad_iir_to_pwm_duty.sv]
// each accepted item passes through the multiply-accumulate steps, one divider
//   load, one divide step per quotient bit plus a done cycle, one output load
//   and one idle; in_stall holds off a new item until the last is through
// the next item is taken while a finished result still waits on the output
// reset: synchronous active-low rst_n restores register defaults and clears
//   the input and output delay lines
module biquad_iir_to_pwm_duty #(
  parameter int ADC_SHIFT = 5,
  parameter int PWM_STEPS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [biq_pkg::SAMPLE_W-1:0]         in_adc_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [biq_pkg::COEF_W-1:0]    out_filtered_value,
  output logic [biq_pkg::OFFSET_W-1:0]         out_duty_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]           cfg_data
);
  import biq_pkg::*;

  localparam int SHIFTED_W = SAMPLE_W - ADC_SHIFT;
  localparam int XW = ((SHIFTED_W > OFFSET_W) ? SHIFTED_W : OFFSET_W) + 1;
  localparam int DUTY_W = COEF_W + 2;
  localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(PWM_STEPS - 1);
  localparam logic [ACC_W-1:0] POS_LIMIT = ACC_W'(32767);
  localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(32768);

  // configuration registers
  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [COEF_W-1:0]        gain_r;
  logic [OFFSET_W-1:0]      offset_r;

  // delay lines and current input
  logic signed [XW-1:0]     x_cur_r, x1_r, x2_r;
  logic signed [COEF_W-1:0] y1_r, y2_r;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r;

  logic                     out_valid_r;
  logic signed [COEF_W-1:0] filt_r;
  logic [OFFSET_W-1:0]      duty_r;

  logic                     in_accept;
  logic                     out_load;
  logic                     div_start;
  mac_ctl_t                 mac_ctl;
  div_sts_t                 div_sts;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [OPND_W-1:0] mac_opnd;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         quo_mag;
  logic                     quo_neg;
  logic [COEF_W-1:0]        divisor;

  logic [SAMPLE_W-1:0]      smp_shift;
  logic signed [XW-1:0]     x_in;
  logic signed [COEF_W-1:0] y_sat;
  logic signed [DUTY_W-1:0] duty_sum;
  logic [OFFSET_W-1:0]      duty_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= 16'sd100;
      b1_r     <= 16'sd200;
      b2_r     <= 16'sd100;
      a1_r     <= 16'sd1634;
      a2_r     <= -16'sd764;
      gain_r   <= 16'd1374;
      offset_r <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_B0:      b0_r     <= cfg_data;
        CFG_B1:      b1_r     <= cfg_data;
        CFG_B2:      b2_r     <= cfg_data;
        CFG_A1:      a1_r     <= cfg_data;
        CFG_A2:      a2_r     <= cfg_data;
        CFG_DIVISOR: gain_r   <= cfg_data;
        CFG_OFFSET:  offset_r <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign smp_shift = in_adc_sample >> ADC_SHIFT;
  assign x_in = $signed(XW'(smp_shift)) - $signed(XW'(offset_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MAC;
      ST_MAC:  if (step_r == STEP_W'(MAC_TAPS)) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_sts.done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    in_accept      = (state_r == ST_IDLE) && in_valid;
    mac_ctl.clear  = in_accept;
    mac_ctl.mul_en = (state_r == ST_MAC) && (step_r < STEP_W'(MAC_TAPS));
    mac_ctl.acc_en = (state_r == ST_MAC) && (step_r != '0);
    div_start      = (state_r == ST_LOAD);
    out_load       = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        step_r <= '0;
      end else if (state_r == ST_MAC) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // tap select for the shared multiplier
  always_comb begin
    mac_coef = '0;
    mac_opnd = '0;
    unique case (step_r)
      3'd0: begin mac_coef = b0_r; mac_opnd = OPND_W'(x_cur_r); end
      3'd1: begin mac_coef = b1_r; mac_opnd = OPND_W'(x1_r); end
      3'd2: begin mac_coef = b2_r; mac_opnd = OPND_W'(x2_r); end
      3'd3: begin mac_coef = a1_r; mac_opnd = y1_r; end
      3'd4: begin mac_coef = a2_r; mac_opnd = y2_r; end
      default: ;
    endcase
  end

  biq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .opnd  (mac_opnd),
    .acc   (acc)
  );

  // a zero divisor acts as one
  assign divisor = (gain_r == '0) ? COEF_W'(1) : gain_r;

  biq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc),
    .divisor  (divisor),
    .quo_mag  (quo_mag),
    .quo_neg  (quo_neg),
    .sts      (div_sts)
  );

  // saturate quotient, then duty
  always_comb begin
    if (quo_neg) begin
      y_sat = (quo_mag > NEG_LIMIT) ? -16'sd32768
                                    : COEF_W'(17'd0 - quo_mag[COEF_W:0]);
    end else begin
      y_sat = (quo_mag > POS_LIMIT) ? 16'sd32767 : $signed(quo_mag[COEF_W-1:0]);
    end
    duty_sum = DUTY_W'(y_sat) + $signed(DUTY_W'(offset_r));
    priority if (duty_sum < 0) begin
      duty_sat = '0;
    end else if (duty_sum > DUTY_MAX) begin
      duty_sat = DUTY_MAX[OFFSET_W-1:0];
    end else begin
      duty_sat = duty_sum[OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (out_load) begin
      x1_r <= x_cur_r;
      x2_r <= x1_r;
      y1_r <= y_sat;
      y2_r <= y1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_cur_r <= x_in;
    end
  end

  // output register holds the item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filt_r <= y_sat;
      duty_r <= duty_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = filt_r;
  assign out_duty_value     = duty_r;

endmodule

[rtl/biq_mac.sv]
module biq_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  biq_pkg::mac_ctl_t                    ctl,
  input  logic signed [biq_pkg::COEF_W-1:0]    coef,
  input  logic signed [biq_pkg::OPND_W-1:0]    opnd,
  output logic signed [biq_pkg::ACC_W-1:0]     acc
);
  import biq_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // product is registered before it reaches the adder
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * opnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

[rtl/biq_div.sv]
module biq_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [biq_pkg::ACC_W-1:0]   dividend,
  input  logic [biq_pkg::COEF_W-1:0]         divisor,
  output logic [biq_pkg::ACC_W-1:0]          quo_mag,
  output logic                               quo_neg,
  output biq_pkg::div_sts_t                  sts
);
  import biq_pkg::*;

  logic [ACC_W-1:0]  quo_r;
  logic [COEF_W-1:0] rem_r;
  logic [COEF_W-1:0] div_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [COEF_W:0]   trial;
  logic              fits;
  logic [COEF_W-1:0] rem_nxt;

  // restoring division, one quotient bit a cycle on the magnitude
  always_comb begin
    trial   = {rem_r, quo_r[ACC_W-1]};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? COEF_W'(trial - {1'b0, div_r}) : trial[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ACC_W-1];
      quo_r <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ACC_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo_mag  = quo_r;
  assign quo_neg  = neg_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
